>>> rtl/core/clpe_pkg.sv
package clpe_pkg;

   localparam int MAX_CELLS_PER_DIM = 16;
   localparam int CELL_CAPACITY     = 16;
   localparam int CELL_SLOTS        = MAX_CELLS_PER_DIM * MAX_CELLS_PER_DIM * MAX_CELLS_PER_DIM;
   localparam int CELL_W            = $clog2(CELL_SLOTS);
   localparam int SLOT_W            = $clog2(CELL_CAPACITY);
   localparam int FILL_W            = $clog2(CELL_CAPACITY + 1);
   localparam int COORD_W           = $clog2(MAX_CELLS_PER_DIM);
   localparam int N_W               = $clog2(MAX_CELLS_PER_DIM + 1);
   localparam int MEMBER_W          = CELL_W + SLOT_W;
   localparam int PID_W             = 10;
   localparam int NB_W              = 4;
   localparam int NB_2D             = 5;
   localparam int NB_3D             = 14;
   localparam int MIN_CELLS         = 3;

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [N_W-1:0]     count_type;

   typedef enum logic [1:0] {
      MODE_CLEAR = 2'd0,
      MODE_LOAD  = 2'd1,
      MODE_START = 2'd2,
      MODE_NEXT  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      OFS_MINUS = 2'd0,
      OFS_ZERO  = 2'd1,
      OFS_PLUS  = 2'd2
   } ofs_type;

   localparam logic       CSR_CELLS_PER_DIM = 1'b0;
   localparam logic       CSR_DIMENSION     = 1'b1;
   localparam logic [1:0] DIM_2D            = 2'd2;

   typedef struct packed {
      ofs_type dx;
      ofs_type dy;
      ofs_type dz;
   } offset_type;

   function automatic offset_type offset_2d(input logic [NB_W-1:0] k);
      offset_type o;
      o.dz = OFS_ZERO;
      unique case (k)
         4'd1:    begin o.dx = OFS_PLUS;  o.dy = OFS_ZERO; end
         4'd2:    begin o.dx = OFS_PLUS;  o.dy = OFS_PLUS; end
         4'd3:    begin o.dx = OFS_ZERO;  o.dy = OFS_PLUS; end
         4'd4:    begin o.dx = OFS_MINUS; o.dy = OFS_PLUS; end
         default: begin o.dx = OFS_ZERO;  o.dy = OFS_ZERO; end
      endcase
      return o;
   endfunction

   function automatic offset_type offset_3d(input logic [NB_W-1:0] k);
      offset_type o;
      unique case (k)
         4'd1:    o = '{OFS_PLUS,  OFS_PLUS,  OFS_PLUS};
         4'd2:    o = '{OFS_PLUS,  OFS_PLUS,  OFS_MINUS};
         4'd3:    o = '{OFS_PLUS,  OFS_MINUS, OFS_PLUS};
         4'd4:    o = '{OFS_PLUS,  OFS_MINUS, OFS_MINUS};
         4'd5:    o = '{OFS_PLUS,  OFS_ZERO,  OFS_ZERO};
         4'd6:    o = '{OFS_ZERO,  OFS_PLUS,  OFS_ZERO};
         4'd7:    o = '{OFS_ZERO,  OFS_ZERO,  OFS_PLUS};
         4'd8:    o = '{OFS_ZERO,  OFS_PLUS,  OFS_PLUS};
         4'd9:    o = '{OFS_PLUS,  OFS_ZERO,  OFS_PLUS};
         4'd10:   o = '{OFS_PLUS,  OFS_PLUS,  OFS_ZERO};
         4'd11:   o = '{OFS_ZERO,  OFS_PLUS,  OFS_MINUS};
         4'd12:   o = '{OFS_PLUS,  OFS_ZERO,  OFS_MINUS};
         4'd13:   o = '{OFS_PLUS,  OFS_MINUS, OFS_ZERO};
         default: o = '{OFS_ZERO,  OFS_ZERO,  OFS_ZERO};
      endcase
      return o;
   endfunction

   function automatic coord_type wrap_coord(input coord_type c, input ofs_type d,
                                            input count_type n);
      coord_type r;
      unique case (d)
         OFS_MINUS: r = (c == '0) ? COORD_W'(n - 1'b1) : c - 1'b1;
         OFS_PLUS:  r = ({1'b0, c} + 1'b1 == n) ? '0 : c + 1'b1;
         default:   r = c;
      endcase
      return r;
   endfunction

   function automatic coord_type mod_coord(input coord_type c, input count_type n);
      count_type r;
      r = {1'b0, c};
      for (int i = 0; i < (MAX_CELLS_PER_DIM - 1) / MIN_CELLS; i++) begin
         if (r >= n) r = r - n;
      end
      return COORD_W'(r);
   endfunction

endpackage

>>> rtl/core/cell_list_pair_enumerator.sv
// Half-shell cell-list pair enumerator. Each accepted item yields exactly one registered
// result strobe; the receiver cannot stall it. Load computes the cell index, reads its fill
// count, then writes the member and the new count. Start or next walk the home cells and
// home slots, try each neighbour cell and read the pair from the member memory. Both the
// fill-count memory and the member memory have registered reads. Clear, and the clearing
// pass after reset, sweep the 4096-entry fill memory at one entry a cycle, with busy held
// high throughout.
module cell_list_pair_enumerator (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_mode,
   input  logic [clpe_pkg::PID_W-1:0]   req_particle_id,
   input  logic [3:0]                   req_cell_x,
   input  logic [3:0]                   req_cell_y,
   input  logic [3:0]                   req_cell_z,
   output logic                         rsp_strobe,
   output logic                         rsp_pair_valid,
   output logic [clpe_pkg::PID_W-1:0]   rsp_first_particle,
   output logic [clpe_pkg::PID_W-1:0]   rsp_second_particle,
   output logic                         rsp_finished,
   output logic                         rsp_overflow,
   input  logic                         csr_write_enable,
   input  logic                         csr_index,
   input  logic [4:0]                   csr_write_data
);
   import clpe_pkg::*;

   typedef enum logic [17:0] {
      ST_IDLE    = 18'h00001,
      ST_INIT    = 18'h00002,
      ST_CLEAR   = 18'h00004,
      ST_LD_CELL = 18'h00008,
      ST_LD_RD   = 18'h00010,
      ST_LD_WR   = 18'h00020,
      ST_SW_RD   = 18'h00040,
      ST_SW_CHK  = 18'h00080,
      ST_NB_MUL  = 18'h00100,
      ST_NB_CELL = 18'h00200,
      ST_NB_RD   = 18'h00400,
      ST_NB_CHK  = 18'h00800,
      ST_HM_RD   = 18'h01000,
      ST_HM_CHK  = 18'h02000,
      ST_MB_HOME = 18'h04000,
      ST_MB_PART = 18'h08000,
      ST_MB_DONE = 18'h10000,
      ST_SPARE   = 18'h20000
   } state_type;

   logic [FILL_W-1:0]  fill_mem [CELL_SLOTS];
   logic [PID_W-1:0]   member_mem [CELL_SLOTS * CELL_CAPACITY];

   state_type          state_ff, state_in;
   logic [CELL_W-1:0]  sweep_ff, sweep_in;
   logic [4:0]         cpd_ff, cpd_in;
   logic [1:0]         dim_ff, dim_in;
   logic [2*N_W-2:0]   nsq_ff;
   logic [CELL_W:0]    nc_ff;
   logic [7:0]         mul_ff, mul_in;
   coord_type          low_ff, low_in;
   logic [CELL_W-1:0]  cell_ff, cell_in;
   logic [CELL_W-1:0]  home_cell_ff, home_cell_in;
   coord_type          hx_ff, hx_in, hy_ff, hy_in, hz_ff, hz_in;
   logic [FILL_W-1:0]  home_slot_ff, home_slot_in;
   logic [NB_W-1:0]    nbr_ff, nbr_in;
   logic [FILL_W-1:0]  partner_ff, partner_in;
   logic               walk_done_ff, walk_done_in;
   logic [PID_W-1:0]   first_ff, first_in;
   logic [PID_W-1:0]   pid_ff, pid_in;
   logic [FILL_W-1:0]  fill_rd_ff;
   logic [PID_W-1:0]   member_rd_ff;

   logic               resp_go, resp_valid, resp_fin, resp_ovf;
   logic [PID_W-1:0]   resp_first, resp_second;
   logic               rsp_strobe_ff, rsp_pair_valid_ff, rsp_finished_ff, rsp_overflow_ff;
   logic [PID_W-1:0]   rsp_first_ff, rsp_second_ff;

   logic [CELL_W-1:0]  fill_addr;
   logic               fill_we;
   logic [CELL_W-1:0]  fill_waddr;
   logic [FILL_W-1:0]  fill_wdata;
   logic [MEMBER_W-1:0] mem_addr;
   logic               mem_we;

   count_type          n_eff;
   logic               is2d;
   logic [NB_W:0]      nb;
   offset_type         ofs;
   coord_type          nx, ny, nz;
   logic [CELL_W-1:0]  cell_calc;
   logic [CELL_W:0]    home_next;
   logic               home_last;
   coord_type          shx, shy, shz;

   always_comb begin
      n_eff = count_type'(cpd_ff);
      if (cpd_ff < 5'(MIN_CELLS)) n_eff = count_type'(MIN_CELLS);
      if (cpd_ff > 5'(MAX_CELLS_PER_DIM)) n_eff = count_type'(MAX_CELLS_PER_DIM);
   end

   assign is2d      = (dim_ff == DIM_2D);
   assign nb        = is2d ? (NB_W+1)'(NB_2D) : (NB_W+1)'(NB_3D);
   assign ofs       = is2d ? offset_2d(nbr_ff) : offset_3d(nbr_ff);
   assign nx        = wrap_coord(hx_ff, ofs.dx, n_eff);
   assign ny        = wrap_coord(hy_ff, ofs.dy, n_eff);
   assign nz        = wrap_coord(hz_ff, ofs.dz, n_eff);
   assign cell_calc = is2d ? CELL_W'(mul_ff)
                           : CELL_W'({4'b0, mul_ff} * {7'b0, n_eff} + {8'b0, low_ff});
   assign home_next = {1'b0, home_cell_ff} + 1'b1;
   assign home_last = (home_next >= nc_ff);
   assign pid_in    = (state_ff == ST_IDLE && start) ? req_particle_id : pid_ff;

   always_comb begin
      shx = hx_ff;
      shy = hy_ff;
      shz = hz_ff;
      if (is2d) begin
         if ({1'b0, hy_ff} + 1'b1 == n_eff) begin
            shy = '0;
            shx = hx_ff + 1'b1;
         end else begin
            shy = hy_ff + 1'b1;
         end
      end else if ({1'b0, hz_ff} + 1'b1 == n_eff) begin
         shz = '0;
         if ({1'b0, hy_ff} + 1'b1 == n_eff) begin
            shy = '0;
            shx = hx_ff + 1'b1;
         end else begin
            shy = hy_ff + 1'b1;
         end
      end else begin
         shz = hz_ff + 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      cpd_in       = cpd_ff;
      dim_in       = dim_ff;
      mul_in       = mul_ff;
      low_in       = low_ff;
      cell_in      = cell_ff;
      home_cell_in = home_cell_ff;
      hx_in        = hx_ff;
      hy_in        = hy_ff;
      hz_in        = hz_ff;
      home_slot_in = home_slot_ff;
      nbr_in       = nbr_ff;
      partner_in   = partner_ff;
      walk_done_in = walk_done_ff;
      first_in     = first_ff;
      resp_go      = 1'b0;
      resp_valid   = 1'b0;
      resp_first   = '0;
      resp_second  = '0;
      resp_fin     = walk_done_ff;
      resp_ovf     = 1'b0;
      fill_addr    = home_cell_ff;
      fill_we      = 1'b0;
      fill_waddr   = sweep_ff;
      fill_wdata   = '0;
      mem_addr     = {home_cell_ff, home_slot_ff[SLOT_W-1:0]};
      mem_we       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (mode_type'(req_mode))
                  MODE_CLEAR: begin
                     walk_done_in = 1'b1;
                     sweep_in     = '0;
                     state_in     = ST_CLEAR;
                  end
                  MODE_LOAD: begin
                     mul_in   = 8'({5'b0, mod_coord(req_cell_x, n_eff)} * {4'b0, n_eff}
                                   + {5'b0, mod_coord(req_cell_y, n_eff)});
                     low_in   = mod_coord(req_cell_z, n_eff);
                     state_in = ST_LD_CELL;
                  end
                  MODE_START: begin
                     home_cell_in = '0;
                     hx_in        = '0;
                     hy_in        = '0;
                     hz_in        = '0;
                     home_slot_in = '0;
                     nbr_in       = '0;
                     partner_in   = '0;
                     walk_done_in = 1'b0;
                     state_in     = ST_SW_RD;
                  end
                  default: begin
                     if (walk_done_ff) begin
                        resp_go = 1'b1;
                     end else begin
                        partner_in = partner_ff + 1'b1;
                        state_in   = ST_NB_MUL;
                     end
                  end
               endcase
            end
         end
         ST_INIT, ST_CLEAR: begin
            fill_we  = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == '1) begin
               state_in = ST_IDLE;
               resp_go  = (state_ff == ST_CLEAR);
               resp_fin = 1'b1;
            end
         end
         ST_LD_CELL: begin
            cell_in  = cell_calc;
            state_in = ST_LD_RD;
         end
         ST_LD_RD: begin
            fill_addr = cell_ff;
            state_in  = ST_LD_WR;
         end
         ST_LD_WR: begin
            resp_go  = 1'b1;
            state_in = ST_IDLE;
            if (fill_rd_ff >= FILL_W'(CELL_CAPACITY)) begin
               resp_ovf = 1'b1;
            end else begin
               fill_we    = 1'b1;
               fill_waddr = cell_ff;
               fill_wdata = fill_rd_ff + 1'b1;
               mem_we     = 1'b1;
               mem_addr   = {cell_ff, fill_rd_ff[SLOT_W-1:0]};
            end
         end
         ST_SW_RD: begin
            state_in = ST_SW_CHK;
         end
         ST_SW_CHK: begin
            if (fill_rd_ff == '0) begin
               if (home_last) begin
                  walk_done_in = 1'b1;
                  resp_go      = 1'b1;
                  resp_fin     = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  home_cell_in = home_next[CELL_W-1:0];
                  hx_in        = shx;
                  hy_in        = shy;
                  hz_in        = shz;
                  state_in     = ST_SW_RD;
               end
            end else begin
               partner_in = partner_ff + 1'b1;
               state_in   = ST_NB_MUL;
            end
         end
         ST_NB_MUL: begin
            mul_in   = 8'({5'b0, nx} * {4'b0, n_eff} + {5'b0, ny});
            low_in   = nz;
            state_in = ST_NB_CELL;
         end
         ST_NB_CELL: begin
            cell_in  = cell_calc;
            state_in = ST_NB_RD;
         end
         ST_NB_RD: begin
            fill_addr = cell_ff;
            state_in  = ST_NB_CHK;
         end
         ST_NB_CHK: begin
            if (partner_ff < fill_rd_ff) begin
               state_in = ST_MB_HOME;
            end else if ({1'b0, nbr_ff} + 1'b1 < nb) begin
               nbr_in     = nbr_ff + 1'b1;
               partner_in = '0;
               state_in   = ST_NB_MUL;
            end else begin
               home_slot_in = home_slot_ff + 1'b1;
               nbr_in       = '0;
               state_in     = ST_HM_RD;
            end
         end
         ST_HM_RD: begin
            state_in = ST_HM_CHK;
         end
         ST_HM_CHK: begin
            if (home_slot_ff >= fill_rd_ff) begin
               if (home_last) begin
                  walk_done_in = 1'b1;
                  resp_go      = 1'b1;
                  resp_fin     = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  home_cell_in = home_next[CELL_W-1:0];
                  hx_in        = shx;
                  hy_in        = shy;
                  hz_in        = shz;
                  home_slot_in = '0;
                  state_in     = ST_HM_RD;
               end
            end else begin
               partner_in = home_slot_ff + 1'b1;
               state_in   = ST_NB_MUL;
            end
         end
         ST_MB_HOME: begin
            state_in = ST_MB_PART;
         end
         ST_MB_PART: begin
            first_in = member_rd_ff;
            mem_addr = {cell_ff, partner_ff[SLOT_W-1:0]};
            state_in = ST_MB_DONE;
         end
         ST_MB_DONE: begin
            resp_go     = 1'b1;
            resp_valid  = 1'b1;
            resp_first  = first_ff;
            resp_second = member_rd_ff;
            resp_fin    = 1'b0;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_write_enable) begin
         walk_done_in = 1'b1;
         if (csr_index == CSR_CELLS_PER_DIM) cpd_in = csr_write_data;
         if (csr_index == CSR_DIMENSION)     dim_in = csr_write_data[1:0];
      end
   end

   always_ff @(posedge clock) begin
      fill_rd_ff <= fill_mem[fill_addr];
      if (fill_we) fill_mem[fill_waddr] <= fill_wdata;
   end

   always_ff @(posedge clock) begin
      member_rd_ff <= member_mem[mem_addr];
      if (mem_we) member_mem[mem_addr] <= pid_ff;
   end

   always_ff @(posedge clock) begin
      pid_ff       <= pid_in;
      nsq_ff       <= (2*N_W-1)'(n_eff * n_eff);
      nc_ff        <= is2d ? (CELL_W+1)'(nsq_ff) : (CELL_W+1)'(nsq_ff * n_eff);
      mul_ff       <= mul_in;
      low_ff       <= low_in;
      cell_ff      <= cell_in;
      first_ff     <= first_in;
      rsp_pair_valid_ff <= resp_valid;
      rsp_first_ff      <= resp_first;
      rsp_second_ff     <= resp_second;
      rsp_finished_ff   <= resp_fin;
      rsp_overflow_ff   <= resp_ovf;
      if (reset) begin
         state_ff      <= ST_INIT;
         sweep_ff      <= '0;
         cpd_ff        <= 5'(MIN_CELLS);
         dim_ff        <= 2'd3;
         home_cell_ff  <= '0;
         hx_ff         <= '0;
         hy_ff         <= '0;
         hz_ff         <= '0;
         home_slot_ff  <= '0;
         nbr_ff        <= '0;
         partner_ff    <= '0;
         walk_done_ff  <= 1'b1;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         cpd_ff        <= cpd_in;
         dim_ff        <= dim_in;
         home_cell_ff  <= home_cell_in;
         hx_ff         <= hx_in;
         hy_ff         <= hy_in;
         hz_ff         <= hz_in;
         home_slot_ff  <= home_slot_in;
         nbr_ff        <= nbr_in;
         partner_ff    <= partner_in;
         walk_done_ff  <= walk_done_in;
         rsp_strobe_ff <= resp_go;
      end
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_pair_valid      = rsp_pair_valid_ff;
   assign rsp_first_particle  = rsp_first_ff;
   assign rsp_second_particle = rsp_second_ff;
   assign rsp_finished        = rsp_finished_ff;
   assign rsp_overflow        = rsp_overflow_ff;

endmodule

>>> sim/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import clpe_pkg::*;

   typedef struct packed {
      logic             pair_valid;
      logic [PID_W-1:0] first_particle;
      logic [PID_W-1:0] second_particle;
      logic             finished;
      logic             overflow;
   } pair_result_type;

   localparam int OFF2_X[5]  = '{0, 1, 1, 0, -1};
   localparam int OFF2_Y[5]  = '{0, 0, 1, 1, 1};
   localparam int OFF3_X[14] = '{0, 1, 1, 1, 1, 1, 0, 0, 0, 1, 1, 0, 1, 1};
   localparam int OFF3_Y[14] = '{0, 1, 1, -1, -1, 0, 1, 0, 1, 0, 1, 1, 0, -1};
   localparam int OFF3_Z[14] = '{0, 1, -1, 1, -1, 0, 0, 1, 1, 1, 0, -1, -1, 0};
   localparam int SLOTS = MAX_CELLS_PER_DIM ** 3;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [1:0]          req_mode;
   logic [PID_W-1:0]    req_particle_id;
   logic [3:0]          req_cell_x;
   logic [3:0]          req_cell_y;
   logic [3:0]          req_cell_z;
   logic                rsp_strobe;
   logic                rsp_pair_valid;
   logic [PID_W-1:0]    rsp_first_particle;
   logic [PID_W-1:0]    rsp_second_particle;
   logic                rsp_finished;
   logic                rsp_overflow;
   logic                csr_write_enable;
   logic                csr_index;
   logic [4:0]          csr_write_data;

   cell_list_pair_enumerator dut (.*);

   // predictor state
   logic [4:0]          grid_size_reg;
   logic [1:0]          grid_dim_reg;
   int unsigned         cell_fill_cnt[SLOTS];
   logic [PID_W-1:0]    cell_members[SLOTS][CELL_CAPACITY];
   int unsigned         home_cell;
   int unsigned         home_slot;
   int unsigned         nb_index;
   int unsigned         partner_slot;
   bit                  walk_done;

   pair_result_type     pending_pairs[$];
   int                  error_count;
   bit                  idling_on;
   int                  items_sent;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic int unsigned grid_n();
      if (grid_size_reg < MIN_CELLS) return MIN_CELLS;
      if (grid_size_reg > MAX_CELLS_PER_DIM) return MAX_CELLS_PER_DIM;
      return grid_size_reg;
   endfunction

   function automatic bit flat_grid();
      return grid_dim_reg == DIM_2D;
   endfunction

   function automatic int unsigned shell_cell(int unsigned h, int unsigned k);
      int unsigned n;
      int x, y, z;
      n = grid_n();
      if (flat_grid()) begin
         y = h % n;
         x = (h / n) % n;
         return ((x + n + OFF2_X[k]) % n) * n + (y + n + OFF2_Y[k]) % n;
      end
      z = h % n;
      y = (h / n) % n;
      x = (h / (n * n)) % n;
      return (((x + n + OFF3_X[k]) % n) * n + (y + n + OFF3_Y[k]) % n) * n
             + (z + n + OFF3_Z[k]) % n;
   endfunction

   function automatic void step_partner();
      int unsigned ncells, nshell;
      ncells = flat_grid() ? grid_n() ** 2 : grid_n() ** 3;
      nshell = flat_grid() ? NB_2D : NB_3D;
      partner_slot++;
      forever begin
         if (partner_slot < cell_fill_cnt[shell_cell(home_cell, nb_index)]) return;
         nb_index++;
         if (nb_index < nshell) begin
            partner_slot = 0;
            continue;
         end
         home_slot++;
         nb_index = 0;
         while (home_slot >= cell_fill_cnt[home_cell]) begin
            home_cell++;
            if (home_cell >= ncells) begin
               walk_done = 1'b1;
               return;
            end
            home_slot = 0;
         end
         partner_slot = home_slot + 1;
      end
   endfunction

   function automatic pair_result_type predict_pair(mode_type m, logic [PID_W-1:0] pid,
                                                    logic [3:0] cx, logic [3:0] cy,
                                                    logic [3:0] cz);
      pair_result_type r;
      int unsigned n, c, ncells;
      r = '0;
      n = grid_n();
      case (m)
         MODE_CLEAR: begin
            foreach (cell_fill_cnt[i]) cell_fill_cnt[i] = 0;
            walk_done = 1'b1;
         end
         MODE_LOAD: begin
            c = flat_grid() ? (cx % n) * n + cy % n
                            : ((cx % n) * n + cy % n) * n + cz % n;
            if (cell_fill_cnt[c] >= CELL_CAPACITY) begin
               r.overflow = 1'b1;
            end else begin
               cell_members[c][cell_fill_cnt[c]] = pid;
               cell_fill_cnt[c]++;
            end
         end
         default: begin
            if (m == MODE_START) begin
               ncells = flat_grid() ? n * n : n * n * n;
               home_cell = 0;
               home_slot = 0;
               nb_index = 0;
               partner_slot = 0;
               walk_done = 1'b0;
               while (!walk_done && cell_fill_cnt[home_cell] == 0) begin
                  home_cell++;
                  if (home_cell >= ncells) walk_done = 1'b1;
               end
               if (!walk_done) step_partner();
            end else if (!walk_done) begin
               step_partner();
            end
            if (!walk_done) begin
               r.pair_valid = 1'b1;
               r.first_particle = cell_members[home_cell][home_slot];
               r.second_particle = cell_members[shell_cell(home_cell, nb_index)][partner_slot];
            end
         end
      endcase
      r.finished = walk_done;
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      pair_result_type e;
      if (!reset && rsp_strobe) begin
         if (pending_pairs.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
         end else begin
            e = pending_pairs.pop_front();
            if (rsp_pair_valid !== e.pair_valid)
               report_mismatch("pair_valid", rsp_pair_valid, e.pair_valid);
            if (rsp_first_particle !== e.first_particle)
               report_mismatch("first_particle", rsp_first_particle, e.first_particle);
            if (rsp_second_particle !== e.second_particle)
               report_mismatch("second_particle", rsp_second_particle, e.second_particle);
            if (rsp_finished !== e.finished)
               report_mismatch("finished", rsp_finished, e.finished);
            if (rsp_overflow !== e.overflow)
               report_mismatch("overflow", rsp_overflow, e.overflow);
         end
      end
   end

   task automatic send_item(mode_type m, logic [PID_W-1:0] pid = '0,
                            logic [3:0] cx = '0, logic [3:0] cy = '0, logic [3:0] cz = '0);
      if (idling_on && $urandom_range(99) < 36) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      start <= 1'b1;
      req_mode <= m;
      req_particle_id <= pid;
      req_cell_x <= cx;
      req_cell_y <= cy;
      req_cell_z <= cz;
      do @(posedge clock); while (busy);
      pending_pairs.insert(pending_pairs.size(), predict_pair(m, pid, cx, cy, cz));
      items_sent++;
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_pairs.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [4:0] value);
      drain();
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_CELLS_PER_DIM) grid_size_reg = value;
      else grid_dim_reg = value[1:0];
      walk_done = 1'b1;
   endtask

   // walk pairs until done or max_steps is reached, with an occasional stray load or start
   task automatic run_walk(int max_steps);
      int steps;
      steps = 0;
      send_item(MODE_START);
      while (!walk_done && steps < max_steps) begin
         if ($urandom_range(99) < 4)
            send_item(MODE_LOAD, PID_W'($urandom), 4'($urandom), 4'($urandom),
                      4'($urandom));
         else if ($urandom_range(99) < 2)
            send_item(MODE_START);
         else
            send_item(MODE_NEXT);
         steps++;
      end
      send_item(MODE_NEXT);
   endtask

   task automatic test_directed();
      send_item(MODE_NEXT);
      send_item(MODE_START);
      send_item(MODE_LOAD, 10'd0, 4'd0, 4'd0, 4'd0);
      send_item(MODE_START);
      send_item(MODE_LOAD, 10'd1023, 4'd15, 4'd15, 4'd15);
      send_item(MODE_LOAD, 10'h155, 4'd2, 4'd2, 4'd2);
      send_item(MODE_LOAD, 10'h2AA, 4'd0, 4'd0, 4'd0);
      send_item(MODE_START);
      send_item(MODE_LOAD, 10'd7, 4'd1, 4'd1, 4'd1);
      repeat (5) send_item(MODE_NEXT);
      send_item(MODE_CLEAR);
      send_item(MODE_NEXT);
      for (int i = 0; i < 17; i++) send_item(MODE_LOAD, PID_W'(i), 4'd1, 4'd2, 4'd0);
      send_item(MODE_CLEAR);
   endtask

   task automatic test_grid(logic [4:0] size, logic [1:0] dim, int particles, int span);
      write_csr(CSR_CELLS_PER_DIM, size);
      write_csr(CSR_DIMENSION, dim);
      send_item(MODE_CLEAR);
      for (int i = 0; i < particles; i++)
         send_item(MODE_LOAD, PID_W'($urandom), 4'($urandom_range(span)),
                   4'($urandom_range(span)), 4'($urandom_range(span)));
      run_walk(150);
   endtask

   task automatic test_random_mix();
      logic [4:0] sizes[6] = '{5'd3, 5'd4, 5'd0, 5'd5, 5'd3, 5'd2};
      while (items_sent < 800) begin
         idling_on = !(items_sent > 450 && items_sent < 600);
         test_grid(sizes[$urandom_range(5)], 2'($urandom), $urandom_range(4, 14), 15);
      end
      idling_on = 1'b1;
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_mode = MODE_CLEAR;
      req_particle_id = '0;
      req_cell_x = '0;
      req_cell_y = '0;
      req_cell_z = '0;
      csr_write_enable = 1'b0;
      csr_index = CSR_CELLS_PER_DIM;
      csr_write_data = '0;
      grid_size_reg = 5'd3;
      grid_dim_reg = 2'd3;
      foreach (cell_fill_cnt[i]) cell_fill_cnt[i] = 0;
      home_cell = 0;
      home_slot = 0;
      nb_index = 0;
      partner_slot = 0;
      walk_done = 1'b1;
      error_count = 0;
      items_sent = 0;
      idling_on = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_grid(5'd3, 2'd2, 12, 15);
      test_grid(5'd16, 2'd2, 14, 2);
      test_grid(5'd16, 2'd3, 10, 1);
      test_grid(5'd31, 2'd1, 8, 15);
      test_grid(5'd3, 2'd0, 20, 15);
      test_random_mix();

      drain();
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/clpe_pkg.sv
rtl/core/cell_list_pair_enumerator.sv
sim/tb_top.sv
